>>> rtl/bbc_pkg.sv
// Package for the bracket balance checker.
// Holds character constants, stack codes, verdict codes and the result struct.
// No dependencies.
package bbc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 1024;

    localparam int CHAR_W    = 8;
    localparam int CODE_W    = 2;
    localparam int VERDICT_W = 2;

    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;  // (
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;  // )
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;  // [
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;  // {
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;  // }

    localparam logic [CODE_W-1:0] CODE_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_ROUND  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_CURLY  = 2'd2;
    localparam logic [CODE_W-1:0] CODE_SQUARE = 2'd3;

    localparam logic [VERDICT_W-1:0] VERDICT_SCANNING  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_MATCHED   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_UNMATCHED = 2'd2;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic                 done;
    } t_result;

    function automatic logic [CODE_W-1:0] opener_code(input logic [CHAR_W-1:0] c);
        logic [CODE_W-1:0] code;
        case (c)
            CH_OPEN_ROUND:  code = CODE_ROUND;
            CH_OPEN_CURLY:  code = CODE_CURLY;
            CH_OPEN_SQUARE: code = CODE_SQUARE;
            default:        code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [CODE_W-1:0] closer_code(input logic [CHAR_W-1:0] c);
        logic [CODE_W-1:0] code;
        case (c)
            CH_CLOSE_ROUND:  code = CODE_ROUND;
            CH_CLOSE_CURLY:  code = CODE_CURLY;
            CH_CLOSE_SQUARE: code = CODE_SQUARE;
            default:         code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/bbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bbc_core.sv
// Stack control for the bracket balance checker: count, failure flag, top of stack.
// Drives the stack RAM; depends on bbc_pkg.
module bbc_core
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [CHAR_W-1:0]              i_char,
    input  logic                           i_last,
    input  logic [CODE_W-1:0]              i_rd_data,
    output logic                           o_wr_en,
    output logic [$clog2(STACK_DEPTH)-1:0] o_wr_addr,
    output logic [CODE_W-1:0]              o_wr_data,
    output logic [$clog2(STACK_DEPTH)-1:0] o_rd_addr,
    output t_result                        o_result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [CW-1:0]     r_count, n_count;
    logic              r_failed, n_failed;
    logic [CODE_W-1:0] r_top, n_top;
    logic [CODE_W-1:0] w_open, w_close;
    logic [CW-1:0]     w_below;

    assign w_open  = opener_code(i_char);
    assign w_close = closer_code(i_char);

    // The top entry lives in r_top. The RAM holds every entry, and each cycle it is
    // read at the slot under the next top, so a pop always finds its new top ready.
    always_comb begin
        n_count   = r_count;
        n_failed  = r_failed;
        n_top     = r_top;
        o_wr_en   = 1'b0;
        o_wr_data = w_open;
        o_result  = '{verdict: VERDICT_SCANNING, done: 1'b0};
        if (i_accept && !r_failed) begin
            if (w_open != CODE_NONE) begin
                if (r_count == CW'(STACK_DEPTH)) begin
                    n_failed = 1'b1;
                end else begin
                    o_wr_en = 1'b1;
                    n_count = r_count + CW'(1);
                    n_top   = w_open;
                end
            end else if (w_close != CODE_NONE) begin
                if (r_count == '0 || r_top != w_close) begin
                    n_failed = 1'b1;
                end else begin
                    n_count = r_count - CW'(1);
                    n_top   = i_rd_data;
                end
            end
        end
        if (i_last) begin
            o_result.done    = 1'b1;
            o_result.verdict = (n_failed || n_count != '0) ? VERDICT_UNMATCHED
                                                           : VERDICT_MATCHED;
        end
        if (i_accept && i_last) begin
            n_count  = '0;
            n_failed = 1'b0;
        end
    end

    assign w_below   = n_count - CW'(2);
    assign o_rd_addr = w_below[AW-1:0];
    assign o_wr_addr = r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_failed <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_failed <= n_failed;
        end
        r_top <= n_top;
    end

endmodule

>>> rtl/bracket_balance_checker.sv
// Top level of the bracket balance checker: stack RAM, stack control, output register.
// Depends on bbc_pkg, bbc_ram and bbc_core.
//
//  Channel | Direction | tdata                        | tlast
//  s_axis  | in        | [7:0] char_code              | last_char
//  m_axis  | out       | [1:0] verdict, [7:2] zero    | string_done
//
// One result per character; a character is taken every cycle while the output
// register is empty or being drained, so throughput is one transfer per cycle.
// The result is registered and shown in the cycle after the transfer. The rate rests on
// the top of stack held in a register and the RAM pre-reading the entry below it.
// Synchronous active-low reset clears count, failure flag and output valid; the
// stack RAM needs no clearing. A stall on m_axis holds the result and stalls s_axis.
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // last_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] verdict, [7:2] zero
    output logic       m_axis_tlast    // string_done
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic              w_accept;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [AW-1:0]     w_rd_addr;
    logic [CODE_W-1:0] w_wr_data;
    logic [CODE_W-1:0] w_rd_data;
    t_result           w_result;

    logic              r_m_valid;
    t_result           r_result;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    bbc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bbc_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_char    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_result.verdict};
    assign m_axis_tlast  = r_result.done;

endmodule
